// ===== sv/vnu_pkg.sv =====
`default_nettype none
package vnu_pkg;
    localparam int COMPONENT_WIDTH = 24;
    localparam int FRACTION_BITS   = 16;
    localparam int NORM_WIDTH      = 18;
    localparam int MAG_WIDTH       = 25;
    localparam int MAGSQ_WIDTH     = 49;
    localparam int RAD_WIDTH       = 2 * MAG_WIDTH;
    localparam int SQRT_STAGES     = MAG_WIDTH;
    localparam int QUOT_WIDTH      = FRACTION_BITS + 1;
    localparam int DIV_STAGES      = QUOT_WIDTH;
    localparam int DIV_REM_WIDTH   = MAG_WIDTH + 1;
    localparam int FRONT_STAGES    = 3;
    localparam int TOTAL_STAGES    = FRONT_STAGES + SQRT_STAGES + DIV_STAGES;
    localparam int LANES           = 4;

    localparam logic [2:0] DIMS_THREE  = 3'd3;
    localparam logic [2:0] DIMS_FOUR   = 3'd4;
    localparam logic [2:0] DIMS_RESET  = 3'd4;
    localparam logic       REG_DIMS    = 1'b0;

    typedef logic [COMPONENT_WIDTH-1:0] comp_t;
    typedef logic [NORM_WIDTH-1:0]      norm_t;
    typedef logic [MAG_WIDTH-1:0]       mag_t;
    typedef logic [MAGSQ_WIDTH-1:0]     magsq_t;

    typedef struct packed {
        logic en;
    } pipe_ctrl_t;
endpackage
`default_nettype wire

// ===== sv/vector_normalize_unit.sv =====
`default_nettype none
// Vector normalization pipeline.
// Input stream (s_*): one transaction carries four signed Q7.16 components,
// packed x, y, z, w from the low bits of s_tdata. Components past the configured
// dimension count are ignored and give zero outputs.
// Output stream (m_*): normalized components in Q1.16, the length in Q9.16, the
// squared length in Q17.32, and a zero-length flag on m_tuser.
// The APB port holds one register at address 0: dimension_count (2, 3 or 4;
// smaller values act as 2, larger as 4). It resets to 4 and should be written
// only while the pipeline is empty.
// Throughput is one transaction per cycle while the receiver keeps up. An input
// passes through three front stages (absolute value, squares, sum), 25
// square-root stages (one root bit each) and 17 divider stages (one quotient
// bit each), then the output register, before its result appears on m_tvalid.
// When the receiver stalls, the whole pipeline freezes and s_tready drops, so
// nothing is lost or repeated; bubbles are not squeezed out during a stall.
// Reset clears all valid bits and the output valid; data registers are not reset.
module vector_normalize_unit (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [95:0]  s_tdata,   // comp_x[23:0], comp_y[47:24], comp_z[71:48], comp_w[95:72]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [151:0] m_tdata,  // norm_x[17:0], norm_y[35:18], norm_z[53:36],
                                   // norm_w[71:54], magnitude[96:72],
                                   // magnitude_squared[145:97], zero pad above
    output logic        m_tuser,   // zero_length
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [2:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vnu_pkg::*;

    // Configuration register.
    logic [2:0] dims_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DIMS) ? {29'd0, dims_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg <= DIMS_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_DIMS) begin
            dims_reg <= pwdata[2:0];
        end
    end

    // Global advance: the pipeline moves whenever the output register can take data.
    pipe_ctrl_t ctrl;
    logic       m_valid_reg;

    assign ctrl.en  = !m_valid_reg || m_tready;
    assign s_tready = ctrl.en;

    logic [TOTAL_STAGES-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctrl.en) begin
            valid_reg <= {valid_reg[TOTAL_STAGES-2:0], s_tvalid};
        end
    end

    // Stage 0: sign split and masking of unused components.
    logic use_lane [LANES];
    assign use_lane[0] = 1'b1;
    assign use_lane[1] = 1'b1;
    assign use_lane[2] = (dims_reg >= DIMS_THREE);
    assign use_lane[3] = (dims_reg >= DIMS_FOUR);

    comp_t          abs0_reg [LANES];
    logic           neg0_reg [LANES];
    comp_t          abs1_reg [LANES];
    logic           neg1_reg [LANES];
    logic [2*COMPONENT_WIDTH-1:0] sq1_reg [LANES];
    comp_t          abs2_reg [LANES];
    logic           neg2_reg [LANES];
    magsq_t         sum2_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            for (int i = 0; i < LANES; i++) begin
                comp_t raw;
                raw = s_tdata[i*COMPONENT_WIDTH +: COMPONENT_WIDTH];
                if (use_lane[i] && raw[COMPONENT_WIDTH-1]) begin
                    abs0_reg[i] <= comp_t'(0) - raw;
                    neg0_reg[i] <= 1'b1;
                end else begin
                    abs0_reg[i] <= use_lane[i] ? raw : '0;
                    neg0_reg[i] <= 1'b0;
                end
            end
            // Stage 1: squares.
            for (int i = 0; i < LANES; i++) begin
                sq1_reg[i]  <= abs0_reg[i] * abs0_reg[i];
                abs1_reg[i] <= abs0_reg[i];
                neg1_reg[i] <= neg0_reg[i];
            end
            // Stage 2: sum of squares; four squares of at most 2^46 fit without overflow.
            sum2_reg <= MAGSQ_WIDTH'(sq1_reg[0]) + MAGSQ_WIDTH'(sq1_reg[1])
                      + MAGSQ_WIDTH'(sq1_reg[2]) + MAGSQ_WIDTH'(sq1_reg[3]);
            for (int i = 0; i < LANES; i++) begin
                abs2_reg[i] <= abs1_reg[i];
                neg2_reg[i] <= neg1_reg[i];
            end
        end
    end

    // Square root.
    mag_t root;

    vnu_sqrt u_sqrt (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .radicand (RAD_WIDTH'(sum2_reg)),
        .root     (root)
    );

    // Side data delayed alongside the square root and the dividers.
    comp_t  absd_reg [SQRT_STAGES][LANES];
    logic   negd_reg [SQRT_STAGES][LANES];
    magsq_t sumd_reg [SQRT_STAGES + DIV_STAGES];
    mag_t   magd_reg [DIV_STAGES];

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            for (int i = 0; i < LANES; i++) begin
                absd_reg[0][i] <= abs2_reg[i];
                negd_reg[0][i] <= neg2_reg[i];
            end
            for (int s = 1; s < SQRT_STAGES; s++) begin
                absd_reg[s] <= absd_reg[s-1];
                negd_reg[s] <= negd_reg[s-1];
            end
            sumd_reg[0] <= sum2_reg;
            for (int s = 1; s < SQRT_STAGES + DIV_STAGES; s++) begin
                sumd_reg[s] <= sumd_reg[s-1];
            end
            magd_reg[0] <= root;
            for (int s = 1; s < DIV_STAGES; s++) begin
                magd_reg[s] <= magd_reg[s-1];
            end
        end
    end

    // One divider lane per component.
    norm_t norm [LANES];

    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            vnu_div u_div (
                .aclk    (aclk),
                .ctrl    (ctrl),
                .abs_val (absd_reg[SQRT_STAGES-1][g]),
                .neg     (negd_reg[SQRT_STAGES-1][g]),
                .mag     (root),
                .norm    (norm[g])
            );
        end
    endgenerate

    // Output register.
    norm_t  norm_out_reg [LANES];
    mag_t   mag_out_reg;
    magsq_t sum_out_reg;
    logic   zero_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.en) begin
            m_valid_reg <= valid_reg[TOTAL_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            norm_out_reg <= norm;
            mag_out_reg  <= magd_reg[DIV_STAGES-1];
            sum_out_reg  <= sumd_reg[SQRT_STAGES + DIV_STAGES - 1];
            zero_out_reg <= (magd_reg[DIV_STAGES-1] == '0);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = zero_out_reg;
    assign m_tdata  = {6'd0, sum_out_reg, mag_out_reg, norm_out_reg[3], norm_out_reg[2],
                       norm_out_reg[1], norm_out_reg[0]};

    // A zero length always comes with zero normalized components.
    a_zero_norm: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[71:0] == 72'd0))
        else $error("zero length with nonzero components");

    // The zero flag agrees with the magnitude field.
    a_zero_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == (m_tdata[96:72] == 25'd0)))
        else $error("zero flag disagrees with magnitude");

    // A stalled pipeline keeps every valid bit in place.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!ctrl.en) |=> $stable(valid_reg))
        else $error("pipeline moved during a stall");

    // Right after reset no result is offered.
    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("output valid after reset");
endmodule
`default_nettype wire

// ===== sv/vnu_sqrt.sv =====
`default_nettype none
// Digit-by-digit square root, one result bit per register stage.
module vnu_sqrt (
    input  wire                                 aclk,
    input  wire vnu_pkg::pipe_ctrl_t            ctrl,
    input  wire [vnu_pkg::RAD_WIDTH-1:0]        radicand,
    output logic [vnu_pkg::MAG_WIDTH-1:0]       root
);
    import vnu_pkg::*;

    localparam int RW = MAG_WIDTH + 3;

    logic [RW-1:0]        rem_reg  [SQRT_STAGES];
    logic [MAG_WIDTH-1:0] root_reg [SQRT_STAGES];
    logic [RAD_WIDTH-1:0] rad_reg  [SQRT_STAGES];

    genvar k;
    generate
        for (k = 0; k < SQRT_STAGES; k++) begin : g_stage
            logic [RW-1:0]        rem_in;
            logic [MAG_WIDTH-1:0] root_in;
            logic [RAD_WIDTH-1:0] rad_in;
            logic [RW-1:0]        rem_sh;
            logic [RW-1:0]        trial;
            logic                 ge;

            if (k == 0) begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign rad_in  = radicand;
            end else begin : g_rest
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign rad_in  = rad_reg[k-1];
            end

            always_comb begin
                rem_sh = {rem_in[RW-3:0], rad_in[RAD_WIDTH-1 -: 2]};
                trial  = RW'({root_in, 2'b01});
                ge     = (rem_sh >= trial);
            end

            always_ff @(posedge aclk) begin
                if (ctrl.en) begin
                    rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
                    root_reg[k] <= {root_in[MAG_WIDTH-2:0], ge};
                    rad_reg[k]  <= {rad_in[RAD_WIDTH-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign root = root_reg[SQRT_STAGES-1];
endmodule
`default_nettype wire

// ===== sv/vnu_div.sv =====
`default_nettype none
// Restoring divider for one lane: |comp| * 2^FRACTION_BITS / mag, one quotient bit per stage.
module vnu_div (
    input  wire                                  aclk,
    input  wire vnu_pkg::pipe_ctrl_t             ctrl,
    input  wire [vnu_pkg::COMPONENT_WIDTH-1:0]   abs_val,
    input  wire                                  neg,
    input  wire [vnu_pkg::MAG_WIDTH-1:0]         mag,
    output logic [vnu_pkg::NORM_WIDTH-1:0]       norm
);
    import vnu_pkg::*;

    localparam int DW = DIV_REM_WIDTH;

    logic [DW-1:0]         rem_reg  [DIV_STAGES];
    logic [QUOT_WIDTH-1:0] quot_reg [DIV_STAGES];
    logic [MAG_WIDTH-1:0]  mag_reg  [DIV_STAGES];
    logic                  neg_reg  [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++) begin : g_stage
            logic [DW-1:0]         rem_in;
            logic [QUOT_WIDTH-1:0] quot_in;
            logic [MAG_WIDTH-1:0]  mag_in;
            logic                  neg_in;
            logic                  bit_in;
            logic [DW-1:0]         rem_sh;
            logic                  ge;

            if (k == 0) begin : g_first
                // The dividend's upper bits are already below the divisor.
                assign rem_in  = DW'(abs_val[COMPONENT_WIDTH-1:1]);
                assign quot_in = '0;
                assign mag_in  = mag;
                assign neg_in  = neg;
                assign bit_in  = abs_val[0];
            end else begin : g_rest
                assign rem_in  = rem_reg[k-1];
                assign quot_in = quot_reg[k-1];
                assign mag_in  = mag_reg[k-1];
                assign neg_in  = neg_reg[k-1];
                assign bit_in  = 1'b0;
            end

            always_comb begin
                rem_sh = {rem_in[DW-2:0], bit_in};
                ge     = (rem_sh >= DW'(mag_in));
            end

            always_ff @(posedge aclk) begin
                if (ctrl.en) begin
                    rem_reg[k]  <= ge ? (rem_sh - DW'(mag_in)) : rem_sh;
                    quot_reg[k] <= {quot_in[QUOT_WIDTH-2:0], ge};
                    mag_reg[k]  <= mag_in;
                    neg_reg[k]  <= neg_in;
                end
            end
        end
    endgenerate

    logic [QUOT_WIDTH-1:0] q_lim;
    logic [NORM_WIDTH-1:0] q_ext;

    always_comb begin
        q_lim = quot_reg[DIV_STAGES-1];
        if (mag_reg[DIV_STAGES-1] == '0) begin
            q_lim = '0;
        end else if (q_lim > QUOT_WIDTH'(1 << FRACTION_BITS)) begin
            q_lim = QUOT_WIDTH'(1 << FRACTION_BITS);
        end
        q_ext = NORM_WIDTH'(q_lim);
        norm  = neg_reg[DIV_STAGES-1] ? (NORM_WIDTH'(0) - q_ext) : q_ext;
    end
endmodule
`default_nettype wire

// ===== sim/vnu_checker.sv =====
`default_nettype none
// Watches both streams and the register port, predicts each normalized vector
// and compares it with what the block delivers.
module vnu_checker (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    input  wire          s_tready,
    input  wire [95:0]   s_tdata,
    input  wire          m_tvalid,
    input  wire          m_tready,
    input  wire [151:0]  m_tdata,
    input  wire          m_tuser,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire [2:0]    paddr,
    input  wire [31:0]   pwdata,
    input  wire          pready,
    output int           error_count,
    output int           pending_count,
    output int           vectors_checked,
    output int           zero_vectors
);
    import vnu_pkg::*;

    typedef struct packed {
        norm_t  nx;
        norm_t  ny;
        norm_t  nz;
        norm_t  nw;
        mag_t   mag;
        magsq_t magsq;
        logic   zero;
    } norm_result_t;

    norm_result_t expected_vectors[$];
    logic [2:0]   dims_reg;

    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        rem   = v;
        root  = '0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic norm_result_t normalize(input logic [95:0] vec, input logic [2:0] dreg);
        int            used;
        logic [63:0]   absval[4];
        logic          neg[4];
        logic [63:0]   sum;
        logic [63:0]   len;
        logic [63:0]   q;
        logic [23:0]   raw;
        norm_t         lane[4];
        norm_result_t  r;
        used = (dreg < 2) ? 2 : ((dreg > 4) ? 4 : int'(dreg));
        sum  = '0;
        for (int i = 0; i < 4; i++) begin
            raw = vec[24*i +: 24];
            if (i < used) begin
                neg[i]    = raw[23];
                absval[i] = raw[23] ? (64'd1 << 24) - {40'd0, raw} : {40'd0, raw};
            end else begin
                neg[i]    = 1'b0;
                absval[i] = '0;
            end
            sum = sum + absval[i] * absval[i];
        end
        len = floor_root(sum);
        for (int i = 0; i < 4; i++) begin
            q = '0;
            if (len != 0) begin
                q = (absval[i] << FRACTION_BITS) / len;
                if (q > (64'd1 << FRACTION_BITS)) q = 64'd1 << FRACTION_BITS;
            end
            if (neg[i]) q = -q;
            lane[i] = q[NORM_WIDTH-1:0];
        end
        r.nx    = lane[0];
        r.ny    = lane[1];
        r.nz    = lane[2];
        r.nw    = lane[3];
        r.mag   = len[MAG_WIDTH-1:0];
        r.magsq = sum[MAGSQ_WIDTH-1:0];
        r.zero  = (len == 0);
        return r;
    endfunction

    assign pending_count = expected_vectors.size();

    always @(posedge aclk) begin
        norm_result_t exp_v;
        norm_result_t got;
        if (!aresetn) begin
            dims_reg <= DIMS_RESET;
            expected_vectors.delete();
            error_count     <= 0;
            vectors_checked <= 0;
            zero_vectors    <= 0;
        end else begin
            // Only paddr[2] is decoded: addresses 0 to 3 reach the register, the others are dropped by the block.
            if (psel && penable && pwrite && pready && paddr[2] == REG_DIMS)
                dims_reg <= pwdata[2:0];
            if (s_tvalid && s_tready)
                expected_vectors.push_back(normalize(s_tdata, dims_reg));
            if (m_tvalid && m_tready) begin
                got.nx    = m_tdata[17:0];
                got.ny    = m_tdata[35:18];
                got.nz    = m_tdata[53:36];
                got.nw    = m_tdata[71:54];
                got.mag   = m_tdata[96:72];
                got.magsq = m_tdata[145:97];
                got.zero  = m_tuser;
                if (expected_vectors.size() == 0) begin
                    $error("unexpected result transaction");
                    error_count <= error_count + 1;
                end else begin
                    exp_v = expected_vectors.pop_front();
                    vectors_checked <= vectors_checked + 1;
                    if (exp_v.zero) zero_vectors <= zero_vectors + 1;
                    if (got != exp_v || m_tdata[151:146] != 0) begin
                        error_count <= error_count + 1;
                        if (got.nx != exp_v.nx)
                            $error("norm_x expected %0d got %0d",
                                   $signed(exp_v.nx), $signed(got.nx));
                        if (got.ny != exp_v.ny)
                            $error("norm_y expected %0d got %0d",
                                   $signed(exp_v.ny), $signed(got.ny));
                        if (got.nz != exp_v.nz)
                            $error("norm_z expected %0d got %0d",
                                   $signed(exp_v.nz), $signed(got.nz));
                        if (got.nw != exp_v.nw)
                            $error("norm_w expected %0d got %0d",
                                   $signed(exp_v.nw), $signed(got.nw));
                        if (got.mag != exp_v.mag)
                            $error("magnitude expected %0d got %0d", exp_v.mag, got.mag);
                        if (got.magsq != exp_v.magsq)
                            $error("magnitude_squared expected %0d got %0d",
                                   exp_v.magsq, got.magsq);
                        if (got.zero != exp_v.zero)
                            $error("zero_length expected %0d got %0d", exp_v.zero, got.zero);
                        if (m_tdata[151:146] != 0)
                            $error("m_tdata pad expected 0 got %0h", m_tdata[151:146]);
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none
// Top of the normalization testbench. It creates stimulus on the input stream,
// throttles the result stream, rewrites the dimension register between phases
// and reports the verdict. All prediction and comparison is done in the checker.
module testbench;
    import vnu_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    wire           s_tready;
    logic [95:0]   s_tdata;   // comp_x[23:0], comp_y[47:24], comp_z[71:48], comp_w[95:72]
    wire           m_tvalid;
    logic          m_tready;
    wire  [151:0]  m_tdata;   // norm_x, norm_y, norm_z, norm_w, magnitude, magnitude_squared
    wire           m_tuser;   // zero_length
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    wire  [31:0]   prdata;
    wire           pready;

    int   error_count;
    int   pending_count;
    int   vectors_checked;
    int   zero_vectors;
    int   vectors_sent;
    int   idle_cycles;
    // When set, both sides run back to back with no gaps or stalls.
    logic no_idle;

    vector_normalize_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    vnu_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .error_count     (error_count),
        .pending_count   (pending_count),
        .vectors_checked (vectors_checked),
        .zero_vectors    (zero_vectors)
    );

    // The clock starts low so that the first rising edge lies clear of time zero.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // The watchdog restarts whenever either stream completes a transaction or
    // the register port is busy; a long silence means the pipeline has hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", pending_count);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Receiver: before each result it may hold m_tready low for a random
    // number of cycles, then waits with it high until a transaction completes.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // One vector on the input stream. With no gap tvalid stays high and only
    // the data changes, so the valid never toggles within one time step.
    task automatic send_vector(input logic [23:0] cx, input logic [23:0] cy,
                               input logic [23:0] cz, input logic [23:0] cw);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cw, cz, cy, cx};
        do @(posedge aclk); while (!s_tready);
        vectors_sent++;
    endtask

    // Stops the input, lets every outstanding result drain, then lets the
    // pipeline settle for its full latency.
    task automatic drain_pipeline;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle held until pready.
    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Component mix: half full-range values, plus small values, extremes
    // and zeros so that short vectors and the zero case come up often.
    function automatic logic [23:0] random_component;
        case ($urandom_range(0, 9))
            0:       return 24'h800000;
            1:       return 24'h7FFFFF;
            2:       return 24'd0;
            3, 4:    return 24'($signed($urandom_range(0, 64)) - 32);
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        logic [2:0] dims_plan[10];
        dims_plan = '{3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd5, 3'd7, 3'd6, 3'd3, 3'd2};
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        no_idle  = 1'b0;
        vectors_sent = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed vectors with the reset dimension of four: zero vector, the
        // most negative and most positive components, single-axis vectors whose
        // quotient reaches the full-scale bound, and mixed signs.
        send_vector(24'd0, 24'd0, 24'd0, 24'd0);
        send_vector(24'h800000, 24'h800000, 24'h800000, 24'h800000);
        send_vector(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_vector(24'h800000, 24'd0, 24'd0, 24'd0);
        send_vector(24'd0, 24'h7FFFFF, 24'd0, 24'd0);
        send_vector(24'd0, 24'd0, 24'hFFFFFF, 24'd0);
        send_vector(24'd0, 24'd0, 24'd0, 24'd1);
        send_vector(24'd1, 24'hFFFFFF, 24'd1, 24'hFFFFFF);
        send_vector(24'h010000, 24'h010000, 24'd0, 24'd0);
        send_vector(24'h030000, 24'hFC0000, 24'd0, 24'd0);
        send_vector(24'h7FFFFF, 24'h800000, 24'h000001, 24'hFFFFFF);
        send_vector(24'h555555, 24'hAAAAAA, 24'h333333, 24'hCCCCCC);
        drain_pipeline();

        // Two dimensions: upper components carry junk that must be ignored,
        // including a vector that is zero only in its used components.
        write_register(3'd0, 32'd2);
        send_vector(24'd0, 24'd0, 24'h7FFFFF, 24'h800000);
        send_vector(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_vector(24'd5, 24'd0, 24'h123456, 24'h654321);
        drain_pipeline();

        // Three dimensions, and a write to an unmapped address that must not
        // change the setting.
        write_register(3'd0, 32'd3);
        write_register(3'd4, 32'd2);
        send_vector(24'd0, 24'd0, 24'd0, 24'h7FFFFF);
        send_vector(24'h800000, 24'h800000, 24'h800000, 24'h123456);
        send_vector(24'd0, 24'd0, 24'hFFFFFF, 24'hABCDEF);
        drain_pipeline();

        // Random phases, each under the setting that dims_plan gives it, with an occasional
        // phase that runs without gaps or stalls on either side.
        for (int phase = 0; phase < 10; phase++) begin
            write_register(3'd0, {$urandom} & 32'hFFFFFFF8 | {29'd0, dims_plan[phase]});
            if (phase == 5) write_register(3'd4, $urandom);
            no_idle = (phase % 3 == 1);
            for (int n = 0; n < 200; n++)
                send_vector(random_component(), random_component(),
                            random_component(), random_component());
            no_idle = 1'b0;
            drain_pipeline();
        end

        $display("Sent %0d vectors over dimension settings 0 through 7; checked %0d results,",
                 vectors_sent, vectors_checked);
        $display("%0d of them zero-length, with random gaps and back-to-back runs.",
                 zero_vectors);
        if (error_count == 0 && pending_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
sv/vnu_pkg.sv
sv/vnu_sqrt.sv
sv/vnu_div.sv
sv/vector_normalize_unit.sv
sim/vnu_checker.sv
sim/testbench.sv
